FILE: rtl/idta_pkg.sv
// Shared types and constants for the IR ranger trimmed-average block.
`default_nettype none

package idta_pkg;

    // Field and state widths
    localparam int DIST_W = 24;
    localparam int SUM_W  = 28;
    localparam int CNT_W  = 4;
    localparam int WIN_W  = 5;

    // Window length limits and reset value
    localparam logic [WIN_W-1:0] WIN_MIN   = 5'd2;
    localparam logic [WIN_W-1:0] WIN_MAX   = 5'd16;
    localparam logic [WIN_W-1:0] WIN_RESET = 5'd10;

    localparam logic [DIST_W-1:0] DIST_MAX = 24'hFFFFFF;

    // distance = (POS_K * 2^B - NEG_K * v + DEN_K/2 * v) / (DEN_K * v)
    localparam logic [17:0] CONV_POS_K = 18'd148480;
    localparam logic [16:0] CONV_NEG_K = 17'd88064;
    localparam logic [5:0]  CONV_DEN_K = 6'd50;

    // Register map (word index)
    localparam logic REG_WINDOW_LENGTH = 1'b0;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_CONV_MUL  = 8'b0000_0010,
        S_CONV_LOAD = 8'b0000_0100,
        S_CONV_DIV  = 8'b0000_1000,
        S_ACCUM     = 8'b0001_0000,
        S_AVG_LOAD  = 8'b0010_0000,
        S_AVG_DIV   = 8'b0100_0000,
        S_EMIT      = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic load_sample;
        logic conv_mul;
        logic conv_load;
        logic accum;
        logic avg_load;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic window_full;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

FILE: rtl/ir_distance_trimmed_average.sv
// Top level of the IR ranger distance averager with maximum rejection.
`default_nettype none

// Takes one raw IR ranger reading per request, converts it to a distance
// 47513.6/sample - 6.88 cm (at 12 bits) in units of 1/256 cm, rounded half up
// and saturated at 0xFFFFFF, and accumulates window_length distances. At the
// end of each window it emits (sum - largest) / (window_length - 1), rounded
// half up, and starts a new window. Both divisions share one restoring
// divider that produces one quotient bit per cycle over NW = max(ADC_BITS+18,
// 29) bits. A sample occupies the block while it is converted, and the
// sample that closes a window holds it further while the average is divided
// and handed to the output register once that register has room. A
// finished average waits in that register without holding up new samples.
// window_length sits at byte address 0; values below 2 act as 2 and above
// 16 as 16. Write it only while the block is idle.
module ir_distance_trimmed_average #(
    parameter int ADC_BITS = 12
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // Sample stream
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [((ADC_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,  // adc_sample
    // Average stream
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [idta_pkg::DIST_W-1:0]               m_axis_tdata,  // mean_distance
    // Configuration
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [2:0]                           paddr,
    input  wire logic [31:0]                          pwdata,
    output logic [31:0]                               prdata,
    output logic                                      pready
);

    logic [idta_pkg::WIN_W-1:0] window_length_reg;
    idta_pkg::cmd_t             cmd;
    idta_pkg::sts_t             sts;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= idta_pkg::WIN_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == idta_pkg::REG_WINDOW_LENGTH) begin
            window_length_reg <= pwdata[idta_pkg::WIN_W-1:0];
        end
    end

    assign prdata = (paddr[2] == idta_pkg::REG_WINDOW_LENGTH)
                  ? {{(32 - idta_pkg::WIN_W){1'b0}}, window_length_reg} : '0;

    idta_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    idta_dp #(
        .ADC_BITS (ADC_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .sample_i      (s_axis_tdata[ADC_BITS-1:0]),
        .window_length (window_length_reg),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .out_data      (m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: rtl/idta_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module idta_div #(
    parameter int NW = 30,
    parameter int DW = 18
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [NW-1:0] num_i,
    input  wire logic [DW-1:0] den_i,
    output logic               done_o,
    output logic [NW-1:0]      quo_o
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= CW'(NW);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num_i;
            rem_reg <= '0;
            den_reg <= den_i;
        end else if (cnt_reg != '0) begin
            quo_reg <= {quo_reg[NW-2:0], ge};
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign done_o = (cnt_reg == '0);
    assign quo_o  = quo_reg;

endmodule

`default_nettype wire

FILE: rtl/idta_dp.sv
// Datapath: sample conversion, window accumulation, averaging and output register.
`default_nettype none

module idta_dp #(
    parameter int ADC_BITS = 12
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire idta_pkg::cmd_t                  cmd,
    output idta_pkg::sts_t                       sts,
    input  wire logic [ADC_BITS-1:0]             sample_i,
    input  wire logic [idta_pkg::WIN_W-1:0]      window_length,
    input  wire logic                            out_ready,
    output logic                                 out_valid,
    output logic [idta_pkg::DIST_W-1:0]          out_data
);

    localparam int PW = ADC_BITS + 17;                 // 88064 * v
    localparam int DW = ADC_BITS + 6;                  // 50 * v
    localparam int NW = (ADC_BITS + 18 > 29) ? ADC_BITS + 18 : 29;

    logic [ADC_BITS-1:0]             sample_reg;
    logic [PW-1:0]                   prod_reg;
    logic [DW-1:0]                   den_reg;
    logic [idta_pkg::SUM_W-1:0]      sum_reg;
    logic [idta_pkg::DIST_W-1:0]     peak_reg;
    logic [idta_pkg::CNT_W-1:0]      count_reg;
    logic [idta_pkg::DIST_W-1:0]     out_data_reg;
    logic                            out_valid_reg;

    logic [ADC_BITS-1:0]             v;
    logic [NW-1:0]                   pos;
    logic [NW-1:0]                   conv_num;
    logic [idta_pkg::WIN_W-1:0]      w;
    logic [idta_pkg::WIN_W-1:0]      wm1;
    logic [idta_pkg::SUM_W-1:0]      trimmed;
    logic [NW-1:0]                   avg_num;
    logic [NW-1:0]                   div_num;
    logic [DW-1:0]                   div_den;
    logic                            div_done;
    logic [NW-1:0]                   quo;
    logic [idta_pkg::DIST_W-1:0]     dist_val;
    logic [idta_pkg::DIST_W-1:0]     peak_next;
    logic [idta_pkg::SUM_W-1:0]      sum_next;
    logic [idta_pkg::WIN_W-1:0]      taken;
    logic                            full;

    // A zero reading counts as one
    assign v   = (sample_reg == '0) ? ADC_BITS'(1) : sample_reg;
    assign pos = NW'(idta_pkg::CONV_POS_K) << ADC_BITS;

    // Clamped to zero when the line goes negative; DEN_K*v/2 rounds half up
    assign conv_num = (pos <= NW'(prod_reg)) ? '0
                    : pos - NW'(prod_reg) + NW'(den_reg >> 1);

    assign w = (window_length < idta_pkg::WIN_MIN) ? idta_pkg::WIN_MIN
             : (window_length > idta_pkg::WIN_MAX) ? idta_pkg::WIN_MAX
             : window_length;
    assign wm1 = w - 1'b1;

    assign trimmed = (sum_reg >= idta_pkg::SUM_W'(peak_reg))
                   ? sum_reg - idta_pkg::SUM_W'(peak_reg) : '0;
    assign avg_num = NW'(trimmed) + NW'(wm1 >> 1);

    assign div_num = cmd.avg_load ? avg_num : conv_num;
    assign div_den = cmd.avg_load ? DW'(wm1) : den_reg;

    idta_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.conv_load | cmd.avg_load),
        .num_i   (div_num),
        .den_i   (div_den),
        .done_o  (div_done),
        .quo_o   (quo)
    );

    assign dist_val = (quo[NW-1:idta_pkg::DIST_W] != '0) ? idta_pkg::DIST_MAX
                    : quo[idta_pkg::DIST_W-1:0];

    assign peak_next = (dist_val > peak_reg) ? dist_val : peak_reg;
    assign sum_next  = sum_reg + idta_pkg::SUM_W'(dist_val);
    assign taken     = {1'b0, count_reg} + 1'b1;
    assign full      = (taken >= w);

    always_ff @(posedge aclk) begin
        if (cmd.load_sample) begin
            sample_reg <= sample_i;
        end
        if (cmd.conv_mul) begin
            prod_reg <= PW'(idta_pkg::CONV_NEG_K) * PW'(v);
            den_reg  <= DW'(idta_pkg::CONV_DEN_K) * DW'(v);
        end
        if (cmd.out_load) begin
            out_data_reg <= quo[idta_pkg::DIST_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            peak_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.accum) begin
                sum_reg   <= sum_next;
                peak_reg  <= peak_next;
                count_reg <= full ? '0 : taken[idta_pkg::CNT_W-1:0];
            end else if (cmd.avg_load) begin
                // Window consumed by the divider load
                sum_reg  <= '0;
                peak_reg <= '0;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.div_done    = div_done;
    assign sts.window_full = full;
    assign sts.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

FILE: rtl/idta_ctrl.sv
// Controller: sequences conversion, accumulation and averaging of one sample.
`default_nettype none

module idta_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire idta_pkg::sts_t sts,
    output idta_pkg::cmd_t      cmd
);

    idta_pkg::state_t state_reg;
    idta_pkg::state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            idta_pkg::S_IDLE: begin
                if (in_valid) begin
                    cmd.load_sample = 1'b1;
                    state_next      = idta_pkg::S_CONV_MUL;
                end
            end
            idta_pkg::S_CONV_MUL: begin
                cmd.conv_mul = 1'b1;
                state_next   = idta_pkg::S_CONV_LOAD;
            end
            idta_pkg::S_CONV_LOAD: begin
                cmd.conv_load = 1'b1;
                state_next    = idta_pkg::S_CONV_DIV;
            end
            idta_pkg::S_CONV_DIV: begin
                if (sts.div_done) begin
                    state_next = idta_pkg::S_ACCUM;
                end
            end
            idta_pkg::S_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = sts.window_full ? idta_pkg::S_AVG_LOAD : idta_pkg::S_IDLE;
            end
            idta_pkg::S_AVG_LOAD: begin
                cmd.avg_load = 1'b1;
                state_next   = idta_pkg::S_AVG_DIV;
            end
            idta_pkg::S_AVG_DIV: begin
                if (sts.div_done) begin
                    state_next = idta_pkg::S_EMIT;
                end
            end
            idta_pkg::S_EMIT: begin
                // Wait for room in the output register
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = idta_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = idta_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= idta_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == idta_pkg::S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/idta_chk.sv
// Port-level checker for the trimmed-average block, bound to the top level.
`default_nettype none

module idta_chk (
    input wire logic                                  aclk,
    input wire logic                                  aresetn,
    input wire logic                                  s_axis_tvalid,
    input wire logic                                  s_axis_tready,
    input wire logic                                  m_axis_tvalid,
    input wire logic                                  m_axis_tready,
    input wire logic [idta_pkg::DIST_W-1:0]           m_axis_tdata,
    input wire logic                                  pready
);

    // A held average keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("average changed while stalled");

    // One sample at a time: ready drops after each accepted request
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second sample taken while converting");

    // An average needs a full conversion first, never straight after a request
    a_no_instant_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("average appeared straight after a sample");

    // Nothing pending out of reset
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_axis_tvalid)
        else $error("output valid after reset");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind ir_distance_trimmed_average idta_chk u_idta_chk (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);

`default_nettype wire

FILE: verif/ir_distance_trimmed_average_tb.sv
// Self-checking testbench for the IR ranger trimmed-average block.
`timescale 1ns / 1ps

module ir_distance_trimmed_average_tb;

    localparam int ADC_BITS = 12;
    localparam int TDATA_W  = ((ADC_BITS + 7) / 8) * 8;
    // slowest request: conversion plus the closing average, with margin
    localparam int SETTLE_CYCLES = 100;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [TDATA_W-1:0]          s_axis_tdata;   // adc_sample
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [idta_pkg::DIST_W-1:0] m_axis_tdata;   // mean_distance
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [2:0]                  paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    ir_distance_trimmed_average #(
        .ADC_BITS(ADC_BITS)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Shadow of the block's window state
    logic [idta_pkg::WIN_W-1:0]  win_len;
    logic [idta_pkg::CNT_W-1:0]  win_count;
    logic [idta_pkg::SUM_W-1:0]  win_sum;
    logic [idta_pkg::DIST_W-1:0] win_peak;

    logic [idta_pkg::DIST_W-1:0] mean_distance_q[$];
    int                          fail_count;
    bit                          idle_en;
    int                          sent_count;
    int                          rx_stall_left;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [idta_pkg::DIST_W-1:0] distance_of(
        input logic [TDATA_W-1:0] raw);
        logic [63:0] v;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] den;
        logic [63:0] q;
        v = 64'(raw[ADC_BITS-1:0]);
        if (v == 0)
            v = 1;
        pos = 64'(idta_pkg::CONV_POS_K) << ADC_BITS;
        neg = 64'(idta_pkg::CONV_NEG_K) * v;
        if (pos <= neg)
            return '0;
        den = 64'(idta_pkg::CONV_DEN_K) * v;
        q = (pos - neg + den / 2) / den;
        if (q > 64'(idta_pkg::DIST_MAX))
            q = 64'(idta_pkg::DIST_MAX);
        return q[idta_pkg::DIST_W-1:0];
    endfunction

    // Adds one accepted sample to the shadow window; queues the mean when it closes.
    task automatic accumulate_sample(input logic [TDATA_W-1:0] raw);
        logic [idta_pkg::DIST_W-1:0] d;
        logic [31:0]                 w;
        logic [31:0]                 taken;
        logic [31:0]                 divisor;
        logic [31:0]                 num;
        logic [31:0]                 mean;
        d = distance_of(raw);
        w = 32'(win_len);
        if (w < 32'(idta_pkg::WIN_MIN))
            w = 32'(idta_pkg::WIN_MIN);
        if (w > 32'(idta_pkg::WIN_MAX))
            w = 32'(idta_pkg::WIN_MAX);
        if (d > win_peak)
            win_peak = d;
        win_sum = win_sum + idta_pkg::SUM_W'(d);
        taken = 32'(win_count) + 1;
        if (taken < w) begin
            win_count = taken[idta_pkg::CNT_W-1:0];
        end else begin
            divisor = w - 1;
            num = (win_sum >= idta_pkg::SUM_W'(win_peak))
                ? 32'(win_sum - idta_pkg::SUM_W'(win_peak)) : 0;
            mean = (num + divisor / 2) / divisor;
            mean_distance_q.push_back(mean[idta_pkg::DIST_W-1:0]);
            win_count = '0;
            win_sum = '0;
            win_peak = '0;
        end
    endtask

    task automatic send_sample(input logic [TDATA_W-1:0] raw);
        int gap;
        gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        forever begin
            @(posedge aclk);
            if (s_axis_tready)
                break;
        end
        accumulate_sample(raw);
        sent_count++;
    endtask

    task automatic stream_idle();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
    endtask

    // Waits for every queued mean, then for the block to finish any conversion.
    task automatic settle_block();
        stream_idle();
        while (mean_distance_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window_length(input logic [idta_pkg::WIN_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idta_pkg::REG_WINDOW_LENGTH, 2'b00};
        pwdata  <= ($urandom() & ~32'h1F) | 32'(value);
        @(negedge aclk);
        penable <= 1'b1;
        forever begin
            @(posedge aclk);
            if (pready)
                break;
        end
        win_len = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [TDATA_W-1:0] pick_sample();
        logic [TDATA_W-1:0] noise;
        noise = TDATA_W'($urandom()) & ~TDATA_W'((1 << ADC_BITS) - 1);
        case ($urandom_range(0, 9))
            0: return TDATA_W'(0);
            1: return TDATA_W'($urandom_range(1, 16));
            2: return TDATA_W'((1 << ADC_BITS) - 1);
            3: return noise | TDATA_W'($urandom_range(0, (1 << ADC_BITS) - 1));
            default: return TDATA_W'($urandom_range(0, (1 << ADC_BITS) - 1));
        endcase
    endfunction

    // Reset window of ten: range extremes and ignored upper bits
    task automatic test_reset_window();
        send_sample(16'h0000);
        send_sample(16'h0001);
        send_sample(16'h0FFF);
        send_sample(16'h0800);
        send_sample(16'hF005);
        send_sample(16'hFFFF);
        send_sample(16'h0003);
        send_sample(16'h0064);
        send_sample(16'h03E8);
        send_sample(16'hAFFE);
        settle_block();
    endtask

    // Lengths below the minimum act as two
    task automatic test_short_windows();
        write_window_length(5'd0);
        send_sample(16'h0000);
        send_sample(16'h0FFF);
        settle_block();
        write_window_length(5'd1);
        send_sample(16'h0001);
        send_sample(16'h5555);
        settle_block();
    endtask

    // Shortening the window below the count closes it on the next sample
    task automatic test_window_shortened();
        write_window_length(5'd16);
        send_sample(16'h0001);
        send_sample(16'h0002);
        send_sample(16'h0FFF);
        send_sample(16'h0000);
        send_sample(16'h0400);
        settle_block();
        write_window_length(5'd3);
        send_sample(16'h0010);
        settle_block();
    endtask

    task automatic test_random_windows();
        logic [idta_pkg::WIN_W-1:0] lengths[8];
        logic [idta_pkg::WIN_W-1:0] len;
        int phase;
        int n;
        lengths = '{5'd2, 5'd16, 5'd31, 5'd17, 5'd5, 5'd0, 5'd1, 5'd10};
        phase = 0;
        while (sent_count < 1650) begin
            // the closing stretch runs at full rate on both sides
            if (sent_count > 1450)
                idle_en = 1'b0;
            len = (phase < 8) ? lengths[phase]
                : idta_pkg::WIN_W'($urandom_range(0, 31));
            write_window_length(len);
            n = $urandom_range(1, 60);
            repeat (n) send_sample(pick_sample());
            settle_block();
            phase++;
        end
    endtask

    // Result stall pattern
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_axis_tready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            rx_stall_left = $urandom_range(0, 4);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        logic [idta_pkg::DIST_W-1:0] want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (mean_distance_q.size() == 0) begin
                $error("mean_distance: no result expected, actual %0d", m_axis_tdata);
                fail_count++;
            end else begin
                want = mean_distance_q.pop_front();
                if (m_axis_tdata !== want) begin
                    $error("mean_distance: expected %0d, actual %0d", want, m_axis_tdata);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        fail_count    = 0;
        sent_count    = 0;
        rx_stall_left = 0;
        idle_en       = 1'b1;
        win_len       = idta_pkg::WIN_RESET;
        win_count     = '0;
        win_sum       = '0;
        win_peak      = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_window();
        test_short_windows();
        test_window_shortened();
        test_random_windows();

        settle_block();
        if (fail_count == 0 && mean_distance_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: ir_distance_trimmed_average.f
rtl/idta_pkg.sv
rtl/idta_div.sv
rtl/idta_dp.sv
rtl/idta_ctrl.sv
rtl/ir_distance_trimmed_average.sv
rtl/idta_chk.sv
verif/ir_distance_trimmed_average_tb.sv
